// ===== design/tsase_pkg.sv =====
// Package with the opcode and status codes of the Thumb shift/add/subtract executor.
`default_nettype none

package tsase_pkg;

    typedef enum logic [2:0] {
        OP_LSL   = 3'd0,
        OP_LSR   = 3'd1,
        OP_ASR   = 3'd2,
        OP_ADDSUB = 3'd3,
        OP_MOV   = 3'd4,
        OP_CMP   = 3'd5,
        OP_ADDI8 = 3'd6,
        OP_SUBI8 = 3'd7
    } t_op;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNDEF = 1'b1;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FLAGS_W = 4;

    localparam logic [1:0] CLASS_SHIFT_ADD = 2'b00;

endpackage

`default_nettype wire

// ===== design/thumb_shift_add_sub_executor.sv =====
// Top level of the Thumb shift/add/subtract/move/compare executor.
//
// The request channel (i_valid, o_ready, i_instruction) takes one 16-bit Thumb
// halfword per request. The result channel (o_valid, i_ready and the o_ payload
// ports) returns one result per request, in order.
// The eight low registers live in a small two-read, one-write memory with a
// registered read; the NZCV flags are a register.
// A request is read from the register memory at the edge that accepts it, is
// executed in the execute stage and lands in the output register when that
// stage advances, which waits while the output holds a result not yet taken.
// Throughput is one request per cycle while the receiver keeps up: a write-back
// that meets a read of the same register at one edge forwards the new value
// into the read register.
// Reset marks every register entry as zero through per-entry valid bits and
// clears the flags and both stages; no clearing pass is needed.
// When the receiver stalls, the output register holds its result, the execute
// stage holds one more request, and o_ready falls only when both are full.
`default_nettype none

module thumb_shift_add_sub_executor #(
    parameter int REG_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_instruction,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_status,
    output logic             o_reg_written,
    output logic [2:0]       o_dest_index,
    output logic [31:0]      o_dest_value,
    output logic [3:0]       o_flags_nzcv
);

    localparam int IDX_W = $clog2(REG_COUNT);

    logic [31:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_mem_vld;

    logic             r_s1_valid;
    logic [15:0]      r_s1_instr;
    logic [31:0]      r_rd_a;
    logic [31:0]      r_rd_b;
    logic [3:0]       r_flags;

    logic             r_out_valid;
    logic             r_out_status;
    logic             r_out_wrote;
    logic [2:0]       r_out_idx;
    logic [31:0]      r_out_val;
    logic [3:0]       r_out_flags;

    logic             accept;
    logic             s1_advance;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;

    logic             wr_en;
    logic [IDX_W-1:0] waddr;
    logic [2:0]       dest_idx;
    logic [31:0]      result;
    logic [3:0]       n_flags;
    logic             undef;
    logic             wrote;

    tsase_pkg::t_op   op;
    logic [4:0]       imm5;
    logic [7:0]       imm8;
    logic [1:0]       sel;
    logic [32:0]      lsl_wide;
    logic [5:0]       shamt;
    logic signed [33:0] sr_src;
    logic signed [33:0] sr_wide;
    logic             sub;
    logic [31:0]      add_b;
    logic [31:0]      add_bb;
    logic [32:0]      sum;
    logic [3:0]       add_flags;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_s1_valid || s1_advance;
    assign accept     = i_valid && o_ready;

    always_comb begin
        if (i_instruction[13:11] > 3'd3) begin
            raddr_a = i_instruction[8 +: IDX_W];
        end else begin
            raddr_a = i_instruction[3 +: IDX_W];
        end
        raddr_b = i_instruction[6 +: IDX_W];
    end

    // Register memory: one write port, two registered read ports with forwarding.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= result;
        end
        if (accept) begin
            if (wr_en && waddr == raddr_a) begin
                r_rd_a <= result;
            end else if (r_mem_vld[raddr_a]) begin
                r_rd_a <= r_mem[raddr_a];
            end else begin
                r_rd_a <= '0;
            end
            if (wr_en && waddr == raddr_b) begin
                r_rd_b <= result;
            end else if (r_mem_vld[raddr_b]) begin
                r_rd_b <= r_mem[raddr_b];
            end else begin
                r_rd_b <= '0;
            end
            r_s1_instr <= i_instruction;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld  <= '0;
            r_s1_valid <= 1'b0;
            r_flags    <= '0;
        end else begin
            if (wr_en) begin
                r_mem_vld[waddr] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_flags <= n_flags;
            end
        end
    end

    // Execute stage.
    always_comb begin
        op    = tsase_pkg::t_op'(r_s1_instr[13:11]);
        imm5  = r_s1_instr[10:6];
        imm8  = r_s1_instr[7:0];
        sel   = r_s1_instr[10:9];
        undef = r_s1_instr[15:14] != tsase_pkg::CLASS_SHIFT_ADD;

        lsl_wide = {1'b0, r_rd_a} << imm5;
        shamt    = (imm5 == 5'd0) ? 6'd32 : {1'b0, imm5};
        sr_src   = {(op == tsase_pkg::OP_ASR) && r_rd_a[31], r_rd_a, 1'b0};
        sr_wide  = sr_src >>> shamt;

        sub = ((op == tsase_pkg::OP_ADDSUB) && sel[0]) || (op == tsase_pkg::OP_CMP)
              || (op == tsase_pkg::OP_SUBI8);
        if (op == tsase_pkg::OP_ADDSUB) begin
            add_b = sel[1] ? {29'd0, r_s1_instr[8:6]} : r_rd_b;
        end else begin
            add_b = {24'd0, imm8};
        end
        add_bb = sub ? ~add_b : add_b;
        sum    = {1'b0, r_rd_a} + {1'b0, add_bb} + {32'd0, sub};
        add_flags = {sum[31], sum[31:0] == 32'd0, sum[32],
                     ~(r_rd_a[31] ^ add_bb[31]) & (r_rd_a[31] ^ sum[31])};

        result   = sum[31:0];
        n_flags  = add_flags;
        wrote    = 1'b1;
        dest_idx = r_s1_instr[2:0];

        case (op)
            tsase_pkg::OP_LSL: begin
                if (imm5 == 5'd0) begin
                    result = r_rd_a;
                    n_flags = {r_rd_a[31], r_rd_a == 32'd0, r_flags[1], r_flags[0]};
                end else begin
                    result = lsl_wide[31:0];
                    n_flags = {lsl_wide[31], lsl_wide[31:0] == 32'd0, lsl_wide[32],
                               r_flags[0]};
                end
            end
            tsase_pkg::OP_LSR, tsase_pkg::OP_ASR: begin
                result  = sr_wide[32:1];
                n_flags = {sr_wide[32], sr_wide[32:1] == 32'd0, sr_wide[0], r_flags[0]};
            end
            tsase_pkg::OP_ADDSUB: begin
                result = sum[31:0];
            end
            tsase_pkg::OP_MOV: begin
                result   = {24'd0, imm8};
                n_flags  = {1'b0, imm8 == 8'd0, r_flags[1], r_flags[0]};
                dest_idx = r_s1_instr[10:8];
            end
            tsase_pkg::OP_CMP: begin
                wrote    = 1'b0;
                result   = '0;
                dest_idx = '0;
            end
            tsase_pkg::OP_ADDI8, tsase_pkg::OP_SUBI8: begin
                dest_idx = r_s1_instr[10:8];
            end
            default: begin
                wrote = 1'b0;
            end
        endcase

        if (undef) begin
            wrote    = 1'b0;
            result   = '0;
            dest_idx = '0;
            n_flags  = r_flags;
        end

        waddr = dest_idx[IDX_W-1:0];
        wr_en = s1_advance && wrote;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_status <= undef ? tsase_pkg::STATUS_UNDEF : tsase_pkg::STATUS_OK;
            r_out_wrote  <= wrote;
            r_out_idx    <= dest_idx;
            r_out_val    <= result;
            r_out_flags  <= n_flags;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_reg_written = r_out_wrote;
    assign o_dest_index  = r_out_idx;
    assign o_dest_value  = r_out_val;
    assign o_flags_nzcv  = r_out_flags;

endmodule

`default_nettype wire
